// ----- hw/rtl/krd_pkg.sv -----
// Package: request and status codes, state encoding for the record deque.
`default_nettype none
package krd_pkg;
  typedef enum logic [3:0] {
    REQ_PUSH_FRONT = 4'd0,
    REQ_PUSH_BACK  = 4'd1,
    REQ_POP_FRONT  = 4'd2,
    REQ_POP_BACK   = 4'd3,
    REQ_FRONT      = 4'd4,
    REQ_BACK       = 4'd5,
    REQ_SIZE       = 4'd6,
    REQ_FIND_POS   = 4'd7,
    REQ_FIND_KEY   = 4'd8,
    REQ_GET_POS    = 4'd9,
    REQ_ERASE_POS  = 4'd10,
    REQ_ERASE_KEY  = 4'd11,
    REQ_INSERT     = 4'd12
  } req_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int KEY_W = 32;
  localparam int PAY_W = 64;
  localparam int REC_W = KEY_W + PAY_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_SEARCH = 7'b0000100,
    S_SHUP   = 7'b0001000,
    S_SHDN   = 7'b0010000,
    S_PLACE  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic             we;
    logic             re;
  } mem_ctl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/krd_store.sv -----
// Record store: synchronous RAM with one write and one registered read port.
`default_nettype none
module krd_store import krd_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  wire logic             clk,
  input  wire mem_ctl_t         ctl,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [REC_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [REC_W-1:0] rdata
);
  logic [REC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/keyed_record_deque.sv -----
// Top level: keyed record deque with sequencer over a single record RAM.
//
//  channel | dir | fields
//  in      | in  | req_type entry_key entry_payload req_pos
//  out     | out | status out_key out_payload out_number
//
// Size, pop_back and refused requests go straight to the result; push_back, front,
// back and find_pos touch one record; searches, inserts and erases walk the records
// over the single RAM read port, and inserts and erases move each record with a
// read-then-write shift.
// Reset returns to idle and clears the count and the pending result; the store is never cleared.
// A result waits in the output register; ready drops until it is taken.
`default_nettype none
module keyed_record_deque import krd_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [3:0]        req_type,
  input  wire logic signed [31:0] entry_key,
  input  wire logic [63:0]       entry_payload,
  input  wire logic [6:0]        req_pos,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic signed [31:0]     out_key,
  output logic [63:0]            out_payload,
  output logic [6:0]             out_number
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1) + 1;

  state_t            state;
  logic [3:0]        rq;
  logic [31:0]       k;
  logic [63:0]       p;
  logic [CW-1:0]     n;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     tgt;
  logic              phase;
  mem_ctl_t          ctl;
  logic [AW-1:0]     waddr, raddr;
  logic [REC_W-1:0]  wdata, rdata;
  logic [CW-1:0]     pos_w;

  krd_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk(clk), .ctl(ctl), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign pos_w = CW'(req_pos);

  always_comb begin
    ctl = '{we: 1'b0, re: 1'b0};
    raddr = idx[AW-1:0];
    waddr = idx[AW-1:0];
    wdata = rdata;
    unique case (state)
      S_READ, S_SEARCH: ctl.re = 1'b1;
      S_SHUP: begin
        ctl.re = !phase;
        raddr = AW'(idx - 1'b1);
        ctl.we = phase;
      end
      S_SHDN: begin
        ctl.re = !phase;
        raddr = AW'(idx + 1'b1);
        ctl.we = phase;
      end
      S_PLACE: begin
        ctl.we = 1'b1;
        wdata = {k, p};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      out_valid <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          rq <= req_type; k <= entry_key; p <= entry_payload;
          status <= ST_OK; out_key <= '0; out_payload <= '0; out_number <= '0;
          phase <= 1'b0; idx <= '0;
          state <= S_DONE;
          priority case (req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
              if (n >= CW'(CAPACITY)) status <= ST_FULL;
              else begin
                tgt <= (req_type == REQ_PUSH_FRONT) ? '0 : n;
                idx <= n;
                state <= S_SHUP;
              end
            REQ_POP_FRONT, REQ_POP_BACK:
              if (n == '0) status <= ST_NOTFOUND;
              else if (req_type == REQ_POP_BACK) n <= n - 1'b1;
              else begin idx <= '0; state <= S_SHDN; end
            REQ_FRONT, REQ_BACK:
              if (n == '0) status <= ST_NOTFOUND;
              else begin
                idx <= (req_type == REQ_FRONT) ? '0 : n - 1'b1;
                state <= S_READ;
              end
            REQ_SIZE: out_number <= 7'(n);
            REQ_FIND_POS, REQ_ERASE_POS:
              if (pos_w == '0 || pos_w > n) status <= ST_NOTFOUND;
              else begin
                idx <= pos_w - 1'b1;
                state <= (req_type == REQ_FIND_POS) ? S_READ : S_SHDN;
              end
            REQ_FIND_KEY, REQ_GET_POS, REQ_ERASE_KEY:
              if (n == '0) status <= ST_NOTFOUND;
              else state <= S_SEARCH;
            REQ_INSERT:
              if (pos_w == '0 || pos_w > n + 1'b1) status <= ST_RANGE;
              else if (n >= CW'(CAPACITY)) status <= ST_FULL;
              else begin tgt <= pos_w - 1'b1; idx <= n; state <= S_SHUP; end
            default: status <= ST_RANGE;
          endcase
        end
        S_READ: begin
          if (phase) begin
            out_key <= rdata[REC_W-1 -: KEY_W];
            out_payload <= rdata[PAY_W-1:0];
            state <= S_DONE;
          end
          phase <= !phase;
        end
        S_SEARCH: begin
          if (phase) begin
            if (rdata[REC_W-1 -: KEY_W] == k) begin
              if (rq == REQ_FIND_KEY) begin
                out_key <= rdata[REC_W-1 -: KEY_W];
                out_payload <= rdata[PAY_W-1:0];
                state <= S_DONE;
              end else if (rq == REQ_GET_POS) begin
                out_number <= 7'(idx + 1'b1);
                state <= S_DONE;
              end else begin
                phase <= 1'b0;
                state <= S_SHDN;
              end
            end else if (idx + 1'b1 >= n) begin
              status <= ST_NOTFOUND;
              state <= S_DONE;
              phase <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
              phase <= 1'b0;
            end
          end else phase <= 1'b1;
        end
        S_SHUP: begin
          if (idx == tgt) state <= S_PLACE;
          else begin
            if (phase) idx <= idx - 1'b1;
            phase <= !phase;
          end
        end
        S_PLACE: begin
          n <= n + 1'b1;
          state <= S_DONE;
        end
        S_SHDN: begin
          if (idx + 1'b1 >= n) begin
            n <= n - 1'b1;
            state <= S_DONE;
          end else begin
            if (phase) idx <= idx + 1'b1;
            phase <= !phase;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/krd_checker.sv -----
// Port checker for the keyed record deque, bound to the top level.
`default_nettype none
module krd_checker import krd_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] status,
  input wire logic [31:0] out_key,
  input wire logic [63:0] out_payload,
  input wire logic [6:0] out_number
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_key))
    else $error("result beat changed while stalled");
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("result appeared too early");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> out_key == '0 && out_payload == '0 && out_number == '0)
    else $error("fields nonzero on failed request");
endmodule

bind keyed_record_deque krd_checker u_krd_checker (.*);
`default_nettype wire

// ----- sim/tb_keyed_record_deque.sv -----
// Testbench for the keyed record deque: directed and random requests checked against a local list model.
`timescale 1ns / 100ps
module tb_keyed_record_deque;
  import krd_pkg::*;

  localparam int CAP = 64;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key;
    logic [63:0]        payload;
    logic [6:0]         number;
  } reply_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic [3:0] req_type = '0;
  logic signed [31:0] entry_key = '0;
  logic [63:0] entry_payload = '0;
  logic [6:0] req_pos = '0;
  logic out_ready = 0;
  logic in_ready, out_valid;
  logic [1:0] status;
  logic signed [31:0] out_key;
  logic [63:0] out_payload;
  logic [6:0] out_number;

  logic signed [31:0] list_key[$];
  logic [63:0] list_pay[$];
  reply_t replies_due[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit stall_free = 0;
  int burst_left = 0;

  keyed_record_deque #(.CAPACITY(CAP)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .entry_key(entry_key),
    .entry_payload(entry_payload), .req_pos(req_pos),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_key(out_key),
    .out_payload(out_payload), .out_number(out_number)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int key_index(logic signed [31:0] k);
    foreach (list_key[i]) if (list_key[i] == k) return i;
    return -1;
  endfunction

  function automatic reply_t deque_reply(logic [3:0] rq, logic signed [31:0] k,
                                         logic [63:0] p, logic [6:0] pos);
    reply_t r;
    int n;
    int idx;
    r = '0;
    n = list_key.size();
    case (rq)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (n >= CAP) r.status = ST_FULL;
        else if (rq == REQ_PUSH_FRONT) begin
          list_key.push_front(k); list_pay.push_front(p);
        end else begin
          list_key.push_back(k); list_pay.push_back(p);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (n == 0) r.status = ST_NOTFOUND;
        else if (rq == REQ_POP_FRONT) begin
          void'(list_key.pop_front()); void'(list_pay.pop_front());
        end else begin
          void'(list_key.pop_back()); void'(list_pay.pop_back());
        end
      end
      REQ_FRONT, REQ_BACK: begin
        if (n == 0) r.status = ST_NOTFOUND;
        else begin
          idx = (rq == REQ_FRONT) ? 0 : n - 1;
          r.key = list_key[idx]; r.payload = list_pay[idx];
        end
      end
      REQ_SIZE: r.number = 7'(n);
      REQ_FIND_POS: begin
        if (pos == 0 || pos > n) r.status = ST_NOTFOUND;
        else begin
          r.key = list_key[pos-1]; r.payload = list_pay[pos-1];
        end
      end
      REQ_FIND_KEY, REQ_GET_POS, REQ_ERASE_KEY: begin
        idx = key_index(k);
        if (idx < 0) r.status = ST_NOTFOUND;
        else if (rq == REQ_FIND_KEY) begin
          r.key = list_key[idx]; r.payload = list_pay[idx];
        end else if (rq == REQ_GET_POS) r.number = 7'(idx + 1);
        else begin
          list_key.delete(idx); list_pay.delete(idx);
        end
      end
      REQ_ERASE_POS: begin
        if (pos == 0 || pos > n) r.status = ST_NOTFOUND;
        else begin
          list_key.delete(pos-1); list_pay.delete(pos-1);
        end
      end
      REQ_INSERT: begin
        if (pos == 0 || pos > n + 1) r.status = ST_RANGE;
        else if (n >= CAP) r.status = ST_FULL;
        else begin
          list_key.insert(pos-1, k); list_pay.insert(pos-1, p);
        end
      end
      default: r.status = ST_RANGE;
    endcase
    return r;
  endfunction

  task automatic send_beat(logic [3:0] rq, logic signed [31:0] k,
                           logic [63:0] p, logic [6:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1;
    req_type <= rq;
    entry_key <= k;
    entry_payload <= p;
    req_pos <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    replies_due.push_back(deque_reply(rq, k, p, pos));
  endtask

  function automatic logic signed [31:0] pick_key();
    if (list_key.size() > 0 && $urandom_range(0, 2) != 0)
      return list_key[$urandom_range(0, list_key.size() - 1)];
    return ($urandom_range(0, 1)) ? $signed($urandom()) : $signed($urandom_range(0, 7));
  endfunction

  function automatic logic [6:0] pick_pos();
    int n;
    n = list_key.size();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 7'(n + 1);
      2: return 7'($urandom_range(0, 127));
      default: return 7'($urandom_range(1, n + 1));
    endcase
  endfunction

  task automatic test_directed();
    send_beat(REQ_POP_FRONT, 0, 0, 0);
    send_beat(REQ_POP_BACK, 0, 0, 0);
    send_beat(REQ_FRONT, 0, 0, 0);
    send_beat(REQ_BACK, 0, 0, 0);
    send_beat(REQ_FIND_POS, 0, 0, 1);
    send_beat(REQ_FIND_KEY, 0, 0, 0);
    send_beat(REQ_GET_POS, 0, 0, 0);
    send_beat(REQ_ERASE_POS, 0, 0, 1);
    send_beat(REQ_ERASE_KEY, 0, 0, 0);
    send_beat(REQ_INSERT, 32'sh7fffffff, '1, 0);
    send_beat(REQ_INSERT, 32'sh7fffffff, '1, 2);
    send_beat(REQ_INSERT, 32'sh7fffffff, '1, 1);
    send_beat(REQ_PUSH_FRONT, 32'sh80000000, '0, 0);
    send_beat(REQ_PUSH_BACK, -1, 64'h5555_aaaa_0f0f_f0f0, 127);
    send_beat(REQ_INSERT, 3, 64'haaaa_5555_f0f0_0f0f, 4);
    send_beat(REQ_SIZE, 0, 0, 0);
    send_beat(REQ_FIND_POS, 0, 0, 0);
    send_beat(REQ_FIND_POS, 0, 0, 5);
    send_beat(REQ_FIND_POS, 0, 0, 4);
    send_beat(REQ_FIND_KEY, -1, 0, 0);
    send_beat(REQ_GET_POS, 32'sh80000000, 0, 0);
    send_beat(REQ_GET_POS, 12345, 0, 0);
    send_beat(REQ_ERASE_KEY, 3, 0, 0);
    send_beat(4'd13, 0, 0, 0);
    send_beat(4'd15, '1, '1, '1);
  endtask

  task automatic test_fill_full();
    while (list_key.size() < CAP)
      send_beat(4'($urandom_range(0, 1)), $signed($urandom()), {$urandom(), $urandom()}, 0);
    send_beat(REQ_PUSH_FRONT, 1, 1, 0);
    send_beat(REQ_PUSH_BACK, 1, 1, 0);
    send_beat(REQ_INSERT, 1, 1, 7'(CAP + 1));
    send_beat(REQ_INSERT, 1, 1, 7'(CAP + 2));
    send_beat(REQ_INSERT, 1, 1, 1);
    send_beat(REQ_SIZE, 0, 0, 0);
    send_beat(REQ_BACK, 0, 0, 0);
    send_beat(REQ_GET_POS, list_key[CAP-1], 0, 0);
    while (list_key.size() > 0) send_beat(4'($urandom_range(2, 3)), 0, 0, 0);
  endtask

  task automatic test_random(int count);
    int w;
    logic [3:0] rq;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(0, 99);
      if (w < 40 && list_key.size() < 40) rq = ($urandom_range(0, 2) == 0) ? REQ_INSERT
                                                 : 4'($urandom_range(0, 1));
      else if (w < 95) rq = 4'($urandom_range(0, 12));
      else rq = 4'($urandom_range(13, 15));
      send_beat(rq, pick_key(), {$urandom(), $urandom()}, pick_pos());
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    test_random(20);
    hold_off = 0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end else if (stall_free) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    reply_t e;
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected reply status=%0d", status);
        errors++;
      end else begin
        e = replies_due.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (out_key !== e.key) begin
          $error("out_key exp %0d got %0d", e.key, out_key); errors++;
        end
        if (out_payload !== e.payload) begin
          $error("out_payload exp %h got %h", e.payload, out_payload); errors++;
        end
        if (out_number !== e.number) begin
          $error("out_number exp %0d got %0d", e.number, out_number); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    test_directed();
    test_fill_full();
    test_backpressure();
    stall_free = 1;
    test_random(100);
    stall_free = 0;
    test_random(770);
    in_valid <= 0;
    while (replies_due.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
